[sv/dcc_packet_waveform_generator_defines.svh]
// Assertion helpers shared by the generator modules.
`ifndef DCC_PACKET_WAVEFORM_GENERATOR_DEFINES_SVH
`define DCC_PACKET_WAVEFORM_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DCC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dcc_pkg.sv]
package dcc_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int DATA_W          = 48;
    localparam int MAX_BYTES       = DATA_W / 8;
    localparam int BYTE_SLOT_BITS  = 9;     // start bit plus eight data bits
    localparam int COUNT_W         = 4;

    localparam logic [5:0] PREAMBLE_RESET = 6'd22;
    localparam logic [2:0] FILLER_LEN     = 3'd3;
    localparam logic [7:0] IDLE_BYTE      = 8'hFF;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_ENQUEUE = 1'b1;

    localparam logic REG_PREAMBLE_COUNT = 1'b0;
    localparam logic REG_PROG_TRACK     = 1'b1;

    typedef logic [MAX_BYTES-1:0][7:0] tx_bytes_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [2:0]        len;
        logic [7:0]        repeats;
        logic [7:0]        id;
    } queue_entry_t;

    typedef struct packed {
        logic [5:0] preamble_count;
        logic       prog_track;
    } cfg_t;

    typedef struct packed {
        logic       level;
        logic [7:0] tag;
        logic       filler;
    } wave_status_t;

    // Clamp a requested length into 1..MAX_BYTES.
    function automatic logic [2:0] clamp_len(input logic [2:0] len);
        logic [2:0] res;
        res = len;
        if (len == 3'd0) begin
            res = 3'd1;
        end else if (int'(len) > MAX_BYTES) begin
            res = 3'(MAX_BYTES);
        end
        return res;
    endfunction

    // Slot position 0 is the start bit, 1..8 walk the byte MSB first.
    function automatic logic data_bit(input logic [7:0] b, input logic [3:0] idx);
        logic [3:0] pos;
        pos = 4'd8 - idx;
        return (idx == 4'd0) ? 1'b0 : b[pos[2:0]];
    endfunction

    // Idle packet FF 00 FF, or reset packet 00 00 00 on a programming track.
    function automatic tx_bytes_t filler_packet(input logic prog);
        tx_bytes_t pkt;
        pkt = '0;
        if (!prog) begin
            pkt[0] = IDLE_BYTE;
            pkt[2] = IDLE_BYTE;
        end
        return pkt;
    endfunction

endpackage

[sv/dcc_queue.sv]
`include "dcc_packet_waveform_generator_defines.svh"

module dcc_queue import dcc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int FW = $clog2(DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  queue_entry_t  wr_entry,
    input  logic          pop,
    output queue_entry_t  head_entry,
    output logic [FW-1:0] fill,
    output logic [FW-1:0] fill_next,
    output logic          full
);

    queue_entry_t  queue_mem [DEPTH];
    queue_entry_t  head_entry_reg;
    logic [AW-1:0] head_reg, head_next, head_inc;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg;

    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_next = pop ? head_inc : head_reg;
    assign tail_next = !push ? tail_reg :
                       (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);

    always_comb begin
        fill_next = fill_reg;
        priority if (push) begin
            fill_next = fill_reg + FW'(1);
        end else if (pop) begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[tail_reg] <= wr_entry;
        end
    end

    // Prefetch the entry at the next head; bypass a write to that same slot.
    always_ff @(posedge aclk) begin
        if (push && tail_reg == head_next) begin
            head_entry_reg <= wr_entry;
        end else begin
            head_entry_reg <= queue_mem[head_next];
        end
    end

    assign head_entry = head_entry_reg;
    assign fill       = fill_reg;
    assign full       = (fill_reg == FW'(DEPTH));

    `DCC_ASSERT_IMP(a_push_not_full, aclk, aresetn, push, fill_reg != FW'(DEPTH), "push while full")
    `DCC_ASSERT_IMP(a_pop_not_empty, aclk, aresetn, pop, fill_reg != '0, "pop while empty")
    `DCC_ASSERT_NXT(a_push_count, aclk, aresetn, push, fill_reg == $past(fill_reg) + FW'(1), "count")

endmodule

[sv/dcc_wave.sv]
`include "dcc_packet_waveform_generator_defines.svh"

module dcc_wave import dcc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         tick,
    input  cfg_t         cfg,
    input  logic         queue_nonempty,
    input  queue_entry_t head_entry,
    output logic         pop,
    output wave_status_t status
);

    typedef enum logic [2:0] {
        PH_RISE, PH_HOLD, PH_MID, PH_ONE_END,
        PH_ZERO_FALL, PH_LOW5, PH_LOW6, PH_LOW7
    } phase_t;

    localparam logic [3:0] SLOT_LAST = 4'(BYTE_SLOT_BITS - 1);

    phase_t     phase_reg, phase_next;
    logic       level_reg, level_next;
    logic       bit_reg, bit_next;
    logic [6:0] pre_reg, pre_next;
    logic [3:0] bit_index_reg, bit_index_next;
    logic [2:0] byte_index_reg, byte_index_next, byte_index_inc;
    tx_bytes_t  tx_bytes_reg, tx_bytes_next;
    logic [2:0] tx_len_reg, tx_len_next;
    logic [7:0] rep_reg, rep_next;
    logic [7:0] tag_reg, tag_next;
    logic       filler;

    assign byte_index_inc = byte_index_reg + 3'd1;

    always_comb begin
        phase_next      = phase_reg;
        level_next      = level_reg;
        bit_next        = bit_reg;
        pre_next        = pre_reg;
        bit_index_next  = bit_index_reg;
        byte_index_next = byte_index_reg;
        tx_bytes_next   = tx_bytes_reg;
        tx_len_next     = tx_len_reg;
        rep_next        = rep_reg;
        tag_next        = tag_reg;
        pop             = 1'b0;
        filler          = 1'b0;
        if (tick) begin
            unique case (phase_reg)
                PH_RISE: begin
                    level_next = 1'b1;
                    phase_next = PH_HOLD;
                    // bit selection for the bit that starts now
                    if (pre_reg != '0) begin
                        bit_next = 1'b1;
                        pre_next = pre_reg - 7'd1;
                    end else begin
                        bit_next = data_bit(tx_bytes_reg[byte_index_reg], bit_index_reg);
                        if (bit_index_reg != SLOT_LAST) begin
                            bit_index_next = bit_index_reg + 4'd1;
                        end else begin
                            bit_index_next = '0;
                            if (byte_index_inc < tx_len_reg) begin
                                byte_index_next = byte_index_inc;
                            end else begin
                                // end of packet
                                byte_index_next = '0;
                                pre_next = {1'b0, cfg.preamble_count} + 7'd1;
                                if (rep_reg != '0) begin
                                    rep_next = rep_reg - 8'd1;
                                end else if (queue_nonempty) begin
                                    pop           = 1'b1;
                                    tx_bytes_next = tx_bytes_t'(head_entry.data);
                                    tx_len_next   = head_entry.len;
                                    rep_next      = head_entry.repeats;
                                    tag_next      = head_entry.id;
                                end else begin
                                    filler        = 1'b1;
                                    tx_bytes_next = filler_packet(cfg.prog_track);
                                    tx_len_next   = FILLER_LEN;
                                    rep_next      = '0;
                                end
                            end
                        end
                    end
                end
                PH_HOLD: begin
                    phase_next = PH_MID;
                end
                PH_MID: begin
                    if (bit_reg) begin
                        level_next = 1'b0;
                    end
                    phase_next = PH_ONE_END;
                end
                PH_ONE_END: begin
                    phase_next = bit_reg ? PH_RISE : PH_ZERO_FALL;
                end
                PH_ZERO_FALL: begin
                    level_next = 1'b0;
                    phase_next = PH_LOW5;
                end
                PH_LOW5: begin
                    phase_next = PH_LOW6;
                end
                PH_LOW6: begin
                    phase_next = PH_LOW7;
                end
                PH_LOW7: begin
                    phase_next = PH_RISE;
                end
                default: begin
                    phase_next = PH_RISE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_RISE;
            level_reg      <= 1'b0;
            bit_reg        <= 1'b0;
            pre_reg        <= '0;
            bit_index_reg  <= '0;
            byte_index_reg <= '0;
            tx_bytes_reg   <= filler_packet(1'b0);
            tx_len_reg     <= FILLER_LEN;
            rep_reg        <= '0;
            tag_reg        <= '0;
        end else begin
            phase_reg      <= phase_next;
            level_reg      <= level_next;
            bit_reg        <= bit_next;
            pre_reg        <= pre_next;
            bit_index_reg  <= bit_index_next;
            byte_index_reg <= byte_index_next;
            tx_bytes_reg   <= tx_bytes_next;
            tx_len_reg     <= tx_len_next;
            rep_reg        <= rep_next;
            tag_reg        <= tag_next;
        end
    end

    assign status.level  = level_next;
    assign status.tag    = tag_next;
    assign status.filler = filler;

    `DCC_ASSERT_NXT(a_rise_high, aclk, aresetn, tick && phase_reg == PH_RISE, level_reg, "rise")
    `DCC_ASSERT_IMP(a_slot_range, aclk, aresetn, 1'b1, bit_index_reg <= SLOT_LAST, "slot index")
    `DCC_ASSERT_IMP(a_pop_at_end, aclk, aresetn, pop,
        tick && phase_reg == PH_RISE && pre_reg == '0 && rep_reg == '0, "pop timing")

endmodule

[sv/dcc_packet_waveform_generator.sv]
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  cmd, packet_data/length/repeats/id
// m_        out        m_valid / m_ready  signal_level, queue_accepted,
//                                         transmit_id, idle_loaded, queue_count
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// One request per cycle; its result appears in the output register the next cycle.
// s_ready drops only while a result is held by m_ready low.
// Packet queue lives in a one-read one-write memory with a registered prefetch of the head.
// aresetn is synchronous: empty queue, idle packet loaded, preamble count 22.
module dcc_packet_waveform_generator import dcc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [5:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [DATA_W-1:0]  s_packet_data,
    input  logic [2:0]         s_packet_length,
    input  logic [7:0]         s_packet_repeats,
    input  logic [7:0]         s_packet_id,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_signal_level,
    output logic               m_queue_accepted,
    output logic [7:0]         m_transmit_id,
    output logic               m_idle_loaded,
    output logic [COUNT_W-1:0] m_queue_count
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    cfg_t          cfg_reg;
    logic          accept, tick, push, pop, full;
    queue_entry_t  wr_entry, head_entry;
    logic [FW-1:0] fill, fill_next;
    wave_status_t  status;

    logic               m_valid_reg;
    logic               level_out_reg;
    logic               accepted_out_reg;
    logic [7:0]         tag_out_reg;
    logic               filler_out_reg;
    logic [COUNT_W-1:0] count_out_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign tick    = accept && (s_cmd == CMD_TICK);
    assign push    = accept && (s_cmd == CMD_ENQUEUE) && !full;

    assign wr_entry.data    = s_packet_data;
    assign wr_entry.len     = clamp_len(s_packet_length);
    assign wr_entry.repeats = s_packet_repeats;
    assign wr_entry.id      = s_packet_id;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.preamble_count <= PREAMBLE_RESET;
            cfg_reg.prog_track     <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PREAMBLE_COUNT: cfg_reg.preamble_count <= cfg_wdata;
                REG_PROG_TRACK:     cfg_reg.prog_track     <= cfg_wdata[0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    dcc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .wr_entry   (wr_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .fill       (fill),
        .fill_next  (fill_next),
        .full       (full)
    );

    dcc_wave u_wave (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tick           (tick),
        .cfg            (cfg_reg),
        .queue_nonempty (fill != '0),
        .head_entry     (head_entry),
        .pop            (pop),
        .status         (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            level_out_reg    <= status.level;
            accepted_out_reg <= push;
            tag_out_reg      <= status.tag;
            filler_out_reg   <= status.filler;
            count_out_reg    <= COUNT_W'(fill_next);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_signal_level   = level_out_reg;
    assign m_queue_accepted = accepted_out_reg;
    assign m_transmit_id    = tag_out_reg;
    assign m_idle_loaded    = filler_out_reg;
    assign m_queue_count    = count_out_reg;

endmodule
